[hdl/plrc_pkg.sv]
// package of types and constants for the packet loss report controller
`timescale 1ns / 1ps

package plrc_pkg;

    localparam logic [1:0] MODE_LOST = 2'd0;
    localparam logic [1:0] MODE_RECV = 2'd1;
    localparam logic [1:0] MODE_PEER = 2'd2;

    localparam logic [1:0] KIND_REPORT   = 2'd0;
    localparam logic [1:0] KIND_FRACTION = 2'd1;
    localparam logic [1:0] KIND_REJECTED = 2'd2;

    localparam logic [1:0] CFG_SEND_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_MIN_EVENTS    = 2'd1;
    localparam logic [1:0] CFG_NOTIFY_EN     = 2'd2;

    localparam logic [15:0] SEND_INTERVAL_RST = 16'd950;
    localparam logic [15:0] MIN_EVENTS_RST    = 16'd30;
    localparam logic        NOTIFY_EN_RST     = 1'b1;

    localparam logic [15:0] EVENTS_MAX = 16'hFFFF;

    localparam int FRAC_W     = 17;
    localparam int DIV_CNT_W  = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_FIRST = DIV_CNT_W'(FRAC_W - 1);

    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 88;

    typedef struct packed {
        logic capture;
        logic eval;
        logic div_step;
        logic load_frac;
    } plrc_cmd_t;

    typedef struct packed {
        logic out_free;
        logic need_div;
        logic div_last;
    } plrc_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FRAC = 4'b1000
    } plrc_state_t;

endpackage

[hdl/plrc_ctrl.sv]
// controller state machine: sequences capture, evaluation, division and result load
`timescale 1ns / 1ps

module plrc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  plrc_pkg::plrc_stat_t stat,
    output plrc_pkg::plrc_cmd_t  cmd
);

    plrc_pkg::plrc_state_t state_reg;
    plrc_pkg::plrc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plrc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            plrc_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = plrc_pkg::ST_EVAL;
                end
            end
            plrc_pkg::ST_EVAL:
            begin
                if (stat.out_free)
                begin
                    cmd.eval   = 1'b1;
                    state_next = stat.need_div ? plrc_pkg::ST_DIV : plrc_pkg::ST_IDLE;
                end
            end
            plrc_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = plrc_pkg::ST_FRAC;
                end
            end
            plrc_pkg::ST_FRAC:
            begin
                if (stat.out_free)
                begin
                    cmd.load_frac = 1'b1;
                    state_next    = plrc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = plrc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/plrc_datapath.sv]
// datapath: configuration, totals, timers, restoring divider and output register
`timescale 1ns / 1ps

module plrc_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [1:0]                         cfg_index,
    input  logic [15:0]                        cfg_data,
    input  logic [1:0]                         in_mode,
    input  logic [31:0]                        in_byte_count,
    input  logic [31:0]                        in_peer_lost,
    input  logic [31:0]                        in_peer_received,
    input  logic [31:0]                        in_now_ms,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [1:0]                         out_kind,
    output logic [31:0]                        out_report_lost,
    output logic [31:0]                        out_report_received,
    output logic [plrc_pkg::FRAC_W-1:0]        out_loss_fraction,
    input  plrc_pkg::plrc_cmd_t                cmd,
    output plrc_pkg::plrc_stat_t               stat
);

    logic [15:0] send_interval_reg;
    logic [15:0] min_events_reg;
    logic        notify_en_reg;

    logic [1:0]  mode_reg;
    logic [31:0] bytes_reg;
    logic [31:0] plost_reg;
    logic [31:0] precv_reg;
    logic [31:0] now_reg;

    logic [31:0] lost_total_reg;
    logic [31:0] recv_total_reg;
    logic [15:0] events_reg;
    logic [31:0] last_report_reg;
    logic [31:0] last_peer_reg;

    logic [32:0] rem_reg;
    logic [32:0] divisor_reg;
    logic        low_bit_reg;
    logic [plrc_pkg::FRAC_W-1:0] quo_reg;
    logic [plrc_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [31:0] out_lost_reg;
    logic [31:0] out_recv_reg;
    logic [plrc_pkg::FRAC_W-1:0] out_frac_reg;

    logic        is_lost;
    logic        is_recv;
    logic        is_peer;
    logic [31:0] lost_new;
    logic [31:0] recv_new;
    logic [15:0] events_new;
    logic [31:0] report_elapsed;
    logic [31:0] peer_elapsed;
    logic        report_due;
    logic        peer_early;
    logic        emit_report;
    logic [33:0] trial;
    logic [33:0] trial_diff;
    logic        trial_ge;

    // evaluation of the captured word
    always_comb
    begin
        is_lost        = (mode_reg == plrc_pkg::MODE_LOST) && (bytes_reg != 32'd0);
        is_recv        = (mode_reg == plrc_pkg::MODE_RECV) && (bytes_reg != 32'd0);
        is_peer        = (mode_reg == plrc_pkg::MODE_PEER);
        lost_new       = is_lost ? lost_total_reg + bytes_reg : lost_total_reg;
        recv_new       = is_recv ? recv_total_reg + bytes_reg : recv_total_reg;
        events_new     = (is_recv && (events_reg != plrc_pkg::EVENTS_MAX))
                       ? events_reg + 16'd1 : events_reg;
        report_elapsed = now_reg - last_report_reg;
        peer_elapsed   = now_reg - last_peer_reg;
        report_due     = (is_lost || is_recv) && (events_new > min_events_reg)
                       && (report_elapsed > {16'd0, send_interval_reg});
        peer_early     = peer_elapsed < {16'd0, send_interval_reg};
        emit_report    = report_due && (lost_new != 32'd0);
    end

    // one restoring division step
    always_comb
    begin
        trial      = {rem_reg, low_bit_reg};
        trial_diff = trial - {1'b0, divisor_reg};
        trial_ge   = trial >= {1'b0, divisor_reg};
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.need_div = is_peer && !peer_early && (plost_reg != 32'd0) && notify_en_reg;
    assign stat.div_last = (div_cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_interval_reg <= plrc_pkg::SEND_INTERVAL_RST;
            min_events_reg    <= plrc_pkg::MIN_EVENTS_RST;
            notify_en_reg     <= plrc_pkg::NOTIFY_EN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                plrc_pkg::CFG_SEND_INTERVAL: send_interval_reg <= cfg_data;
                plrc_pkg::CFG_MIN_EVENTS:    min_events_reg    <= cfg_data;
                plrc_pkg::CFG_NOTIFY_EN:     notify_en_reg     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            bytes_reg <= in_byte_count;
            plost_reg <= in_peer_lost;
            precv_reg <= in_peer_received;
            now_reg   <= in_now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= plrc_pkg::MODE_LOST;
            lost_total_reg  <= '0;
            recv_total_reg  <= '0;
            events_reg      <= '0;
            last_report_reg <= '0;
            last_peer_reg   <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                mode_reg <= in_mode;
            end
            if (cmd.eval)
            begin
                if (report_due)
                begin
                    lost_total_reg  <= '0;
                    recv_total_reg  <= '0;
                    events_reg      <= '0;
                    last_report_reg <= now_reg;
                end
                else
                begin
                    lost_total_reg <= lost_new;
                    recv_total_reg <= recv_new;
                    events_reg     <= events_new;
                end
                if (is_peer && !peer_early)
                begin
                    last_peer_reg <= now_reg;
                end
            end
        end
    end

    // divider, quotient width bounded since lost never exceeds the sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.eval)
        begin
            div_cnt_reg <= plrc_pkg::DIV_FIRST;
        end
        else if (cmd.div_step && (div_cnt_reg != '0))
        begin
            div_cnt_reg <= div_cnt_reg - plrc_pkg::DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            rem_reg     <= {2'b00, plost_reg[31:1]};
            divisor_reg <= {1'b0, plost_reg} + {1'b0, precv_reg};
            low_bit_reg <= plost_reg[0];
            quo_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= trial_ge ? trial_diff[32:0] : trial[32:0];
            low_bit_reg <= 1'b0;
            quo_reg     <= {quo_reg[plrc_pkg::FRAC_W-2:0], trial_ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.eval && (emit_report || (is_peer && peer_early))) || cmd.load_frac)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval && emit_report)
        begin
            out_kind_reg <= plrc_pkg::KIND_REPORT;
            out_lost_reg <= lost_new;
            out_recv_reg <= recv_new;
            out_frac_reg <= '0;
        end
        else if (cmd.eval && is_peer && peer_early)
        begin
            out_kind_reg <= plrc_pkg::KIND_REJECTED;
            out_lost_reg <= '0;
            out_recv_reg <= '0;
            out_frac_reg <= '0;
        end
        else if (cmd.load_frac)
        begin
            out_kind_reg <= plrc_pkg::KIND_FRACTION;
            out_lost_reg <= '0;
            out_recv_reg <= '0;
            out_frac_reg <= quo_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_kind            = out_kind_reg;
    assign out_report_lost     = out_lost_reg;
    assign out_report_received = out_recv_reg;
    assign out_loss_fraction   = out_frac_reg;

endmodule

[hdl/packet_loss_report_controller_core.sv]
// top level of the packet loss report controller
//
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tuser mode, tdata counts and time
// m_axis    out        m_axis_tvalid/m_axis_tready  tuser kind, tdata totals and fraction
// cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// a lost or received word goes through capture, then evaluate and update
// a peer word with a fraction goes through capture, evaluate, the 17-step restoring divider and fraction load
// evaluate and fraction load wait while a held result is not taken
// rst_n clears control, totals, timers and configuration at once
`timescale 1ns / 1ps

module packet_loss_report_controller_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // byte_count, peer_lost, peer_received, now_ms
    input  logic [plrc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // mode
    input  logic [1:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // report_lost, report_received, loss_fraction, zero fill
    output logic [plrc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // result_kind
    output logic [1:0]                           m_axis_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [1:0]                           cfg_index,
    input  logic [15:0]                          cfg_data
);

    plrc_pkg::plrc_cmd_t  cmd;
    plrc_pkg::plrc_stat_t stat;

    logic [31:0]                  report_lost;
    logic [31:0]                  report_received;
    logic [plrc_pkg::FRAC_W-1:0]  loss_fraction;

    assign cfg_ready = 1'b1;

    plrc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    plrc_datapath u_datapath
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_mode             (s_axis_tuser),
        .in_byte_count       (s_axis_tdata[31:0]),
        .in_peer_lost        (s_axis_tdata[63:32]),
        .in_peer_received    (s_axis_tdata[95:64]),
        .in_now_ms           (s_axis_tdata[127:96]),
        .out_ready           (m_axis_tready),
        .out_valid           (m_axis_tvalid),
        .out_kind            (m_axis_tuser),
        .out_report_lost     (report_lost),
        .out_report_received (report_received),
        .out_loss_fraction   (loss_fraction),
        .cmd                 (cmd),
        .stat                (stat)
    );

    assign m_axis_tdata = {7'd0, loss_fraction, report_received, report_lost};

endmodule

[hdl/plrc_checker.sv]
// port-level checker for the packet loss report controller and its bind
`timescale 1ns / 1ps

module plrc_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [plrc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic [1:0]                        m_axis_tuser
);

    // a held result stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // one word in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while previous word still in work");

    a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == plrc_pkg::KIND_REPORT)
                       || (m_axis_tuser == plrc_pkg::KIND_FRACTION)
                       || (m_axis_tuser == plrc_pkg::KIND_REJECTED))
        else $error("unknown result kind");

    // fraction words carry no totals and stay within one
    a_frac_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == plrc_pkg::KIND_FRACTION)
        |-> (m_axis_tdata[63:0] == 64'd0) && (m_axis_tdata[80:64] <= 17'd65536))
        else $error("malformed fraction word");

    // rejected and report words carry the expected zero fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != plrc_pkg::KIND_FRACTION)
        |-> (m_axis_tdata[87:64] == 24'd0)
         && ((m_axis_tuser != plrc_pkg::KIND_REJECTED) || (m_axis_tdata == '0)))
        else $error("nonzero field in report or rejected word");

endmodule

bind packet_loss_report_controller_core plrc_checker u_plrc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/packet_loss_report_controller_core_tb.sv]
// testbench for the packet loss report controller: streams events and checks results
`timescale 1ns / 1ps

module packet_loss_report_controller_core_tb;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int SHOW_MAX      = 20;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] byte_count;
        logic [31:0] peer_lost;
        logic [31:0] peer_received;
        logic [31:0] now_ms;
    } loss_event_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] lost;
        logic [31:0] received;
        logic [16:0] fraction;
    } notice_t;

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [plrc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]                      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [plrc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]                      m_axis_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [1:0]                      cfg_index = '0;
    logic [15:0]                     cfg_data = '0;

    packet_loss_report_controller_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    loss_event_t event_q[$];
    notice_t     notice_q[$];
    loss_event_t word_on_bus;
    notice_t     oldest_notice;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int shown = 0;
    int n_words = 0;
    int n_reports = 0;
    int n_fractions = 0;
    int n_rejects = 0;
    int quiet_cycles = 0;
    logic [31:0] stamp_ms = '0;

    // controller copy
    logic [15:0] interval_ms = plrc_pkg::SEND_INTERVAL_RST;
    logic [15:0] min_events = plrc_pkg::MIN_EVENTS_RST;
    logic        notify_en = plrc_pkg::NOTIFY_EN_RST;
    logic [31:0] lost_sum = '0;
    logic [31:0] recv_sum = '0;
    logic [15:0] recv_events = '0;
    logic [31:0] report_ms = '0;
    logic [31:0] peer_ms = '0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_if_due(input logic [31:0] now);
        notice_t n;
        logic [31:0] elapsed;
        elapsed = now - report_ms;
        if (recv_events > min_events && elapsed > {16'h0, interval_ms})
        begin
            recv_events = '0;
            if (lost_sum != 0)
            begin
                n.kind = plrc_pkg::KIND_REPORT;
                n.lost = lost_sum;
                n.received = recv_sum;
                n.fraction = '0;
                notice_q.push_back(n);
            end
            report_ms = now;
            lost_sum = '0;
            recv_sum = '0;
        end
    endtask

    task automatic update_loss_state(input loss_event_t ev);
        notice_t n;
        logic [31:0] elapsed;
        logic [32:0] total;
        logic [48:0] quotient;
        n = '0;
        case (ev.mode)
            plrc_pkg::MODE_LOST:
            begin
                if (ev.byte_count != 0)
                begin
                    lost_sum = lost_sum + ev.byte_count;
                    report_if_due(ev.now_ms);
                end
            end
            plrc_pkg::MODE_RECV:
            begin
                if (ev.byte_count != 0)
                begin
                    if (recv_events != plrc_pkg::EVENTS_MAX)
                        recv_events = recv_events + 16'd1;
                    recv_sum = recv_sum + ev.byte_count;
                    report_if_due(ev.now_ms);
                end
            end
            plrc_pkg::MODE_PEER:
            begin
                elapsed = ev.now_ms - peer_ms;
                if (elapsed < {16'h0, interval_ms})
                begin
                    n.kind = plrc_pkg::KIND_REJECTED;
                    notice_q.push_back(n);
                end
                else
                begin
                    peer_ms = ev.now_ms;
                    if (ev.peer_lost != 0 && notify_en)
                    begin
                        total = {1'b0, ev.peer_lost} + {1'b0, ev.peer_received};
                        quotient = {ev.peer_lost, 16'h0} / {16'h0, total};
                        n.kind = plrc_pkg::KIND_FRACTION;
                        n.fraction = quotient[16:0];
                        notice_q.push_back(n);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                update_loss_state(word_on_bus);
                n_words = n_words + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (event_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    word_on_bus = event_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {word_on_bus.now_ms, word_on_bus.peer_received,
                                     word_on_bus.peer_lost, word_on_bus.byte_count};
                    s_axis_tuser <= word_on_bus.mode;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            case (m_axis_tuser)
                plrc_pkg::KIND_REPORT:   n_reports = n_reports + 1;
                plrc_pkg::KIND_FRACTION: n_fractions = n_fractions + 1;
                default:                 n_rejects = n_rejects + 1;
            endcase
            if (notice_q.size() == 0)
            begin
                errors = errors + 1;
                if (shown < SHOW_MAX)
                    $display("%0t unexpected word: expected none, actual kind %0d data %h",
                             $time, m_axis_tuser, m_axis_tdata);
                shown = shown + 1;
            end
            else
            begin
                oldest_notice = notice_q.pop_front();
                if (m_axis_tuser != oldest_notice.kind
                    || m_axis_tdata[31:0] != oldest_notice.lost
                    || m_axis_tdata[63:32] != oldest_notice.received
                    || m_axis_tdata[80:64] != oldest_notice.fraction)
                begin
                    errors = errors + 1;
                    if (shown < SHOW_MAX)
                        $display({"%0t mismatch: expected kind %0d lost %h recv %h frac %h,",
                                  " actual kind %0d lost %h recv %h frac %h"},
                                 $time, oldest_notice.kind, oldest_notice.lost,
                                 oldest_notice.received, oldest_notice.fraction,
                                 m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                                 m_axis_tdata[80:64]);
                    shown = shown + 1;
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t watchdog: no handshake for %0d cycles", $time, quiet_cycles);
                    $display("** packet_loss_report_controller_core: FAILED **");
                    $finish;
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            plrc_pkg::CFG_SEND_INTERVAL: interval_ms = val;
            plrc_pkg::CFG_MIN_EVENTS:    min_events = val;
            plrc_pkg::CFG_NOTIFY_EN:     notify_en = val[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_all();
        @(posedge clk);
        while (event_q.size() > 0 || s_axis_tvalid || notice_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_event(input logic [1:0] mode, input logic [31:0] bytes,
                              input logic [31:0] plost, input logic [31:0] precv,
                              input logic [31:0] now);
        loss_event_t ev;
        ev.mode = mode;
        ev.byte_count = bytes;
        ev.peer_lost = plost;
        ev.peer_received = precv;
        ev.now_ms = now;
        event_q.push_back(ev);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2, 3, 4: return $urandom_range(1, 1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_segment(input logic [15:0] ival, input logic [15:0] mins,
                               input logic en, input int count);
        int r;
        int span;
        logic [1:0] mode;
        write_reg(plrc_pkg::CFG_SEND_INTERVAL, ival);
        write_reg(plrc_pkg::CFG_MIN_EVENTS, mins);
        write_reg(plrc_pkg::CFG_NOTIFY_EN, {15'h0, en});
        write_reg(CFG_UNUSED, 16'($urandom_range(16'hFFFF)));
        span = ival / 6 + 2;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 4)
                stamp_ms = $urandom;
            else
                stamp_ms = stamp_ms + $urandom_range(span);
            r = $urandom_range(99);
            if (r < 60)
                mode = plrc_pkg::MODE_RECV;
            else if (r < 80)
                mode = plrc_pkg::MODE_LOST;
            else if (r < 95)
                mode = plrc_pkg::MODE_PEER;
            else
                mode = MODE_UNUSED;
            push_event(mode, pick_word(), pick_word(), pick_word(), stamp_ms);
        end
        drain_all();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct <= 29;
        recv_idle_pct <= 60;
        @(posedge clk);

        // peer timing, fraction extremes, ignored words, total wrap
        push_event(plrc_pkg::MODE_PEER, 32'h0, 32'd1, 32'd2, 32'd0);
        push_event(plrc_pkg::MODE_PEER, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd950);
        push_event(plrc_pkg::MODE_PEER, 32'h0, 32'd5, 32'd0, 32'd1900);
        push_event(plrc_pkg::MODE_PEER, 32'h0, 32'd0, 32'd123, 32'd2850);
        push_event(plrc_pkg::MODE_PEER, 32'h0, 32'd7, 32'd7, 32'd2851);
        push_event(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom);
        push_event(plrc_pkg::MODE_LOST, 32'h0, $urandom, $urandom, 32'd3000);
        push_event(plrc_pkg::MODE_RECV, 32'h0, $urandom, $urandom, 32'd3000);
        push_event(plrc_pkg::MODE_LOST, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'd3001);
        push_event(plrc_pkg::MODE_LOST, 32'd2, 32'h0, 32'h0, 32'd3002);
        push_event(plrc_pkg::MODE_RECV, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'd3003);
        drain_all();

        // short interval, time wrap, disabled delivery
        write_reg(plrc_pkg::CFG_SEND_INTERVAL, 16'd5);
        write_reg(plrc_pkg::CFG_MIN_EVENTS, 16'd0);
        write_reg(CFG_UNUSED, 16'hFFFF);
        push_event(plrc_pkg::MODE_RECV, 32'd1, 32'h0, 32'h0, 32'hFFFF_FFFE);
        push_event(plrc_pkg::MODE_LOST, 32'd7, 32'h0, 32'h0, 32'd2);
        push_event(plrc_pkg::MODE_RECV, 32'd3, 32'h0, 32'h0, 32'd3);
        push_event(plrc_pkg::MODE_RECV, 32'd4, 32'h0, 32'h0, 32'd4);
        push_event(plrc_pkg::MODE_PEER, 32'h0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_event(plrc_pkg::MODE_PEER, 32'h0, 32'd1, 32'd1, 32'd3);
        push_event(plrc_pkg::MODE_PEER, 32'h0, 32'd1, 32'd1, 32'd4);
        drain_all();
        write_reg(plrc_pkg::CFG_NOTIFY_EN, 16'd0);
        push_event(plrc_pkg::MODE_PEER, 32'h0, 32'd9, 32'd1, 32'd100);
        drain_all();
        stamp_ms = 32'd100;

        run_segment(16'd950, 16'd30, 1'b1, 210);
        run_segment(16'd0, 16'd0, 1'b1, 210);

        send_idle_pct <= 60;
        recv_idle_pct <= 29;
        run_segment(16'hFFFF, 16'd5, 1'b1, 210);
        run_segment(16'd200, 16'hFFFF, 1'b0, 210);

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        run_segment(16'($urandom_range(1, 500)), 16'($urandom_range(20)), 1'b1, 210);
        run_segment(16'($urandom_range(3000)), 16'($urandom_range(10)),
                    1'($urandom_range(1)), 210);

        if (notice_q.size() != 0)
        begin
            errors = errors + 1;
            $display("%0t %0d expected words never arrived", $time, notice_q.size());
        end
        $display("run covered %0d input words with three idle profiles",
                 n_words);
        $display("and several register settings");
        $display("results seen: %0d reports, %0d loss fractions, %0d rejected, %0d errors",
                 n_reports, n_fractions, n_rejects, errors);
        if (errors == 0)
            $display("** packet_loss_report_controller_core: PASSED **");
        else
            $display("** packet_loss_report_controller_core: FAILED **");
        $finish;
    end

endmodule

[sim.f]
hdl/plrc_pkg.sv
hdl/plrc_ctrl.sv
hdl/plrc_datapath.sv
hdl/packet_loss_report_controller_core.sv
hdl/plrc_checker.sv
tb/packet_loss_report_controller_core_tb.sv
